// File: hdl/afp_pkg.sv
package afp_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int NW           = 98;
	localparam int MDW          = 67;
	localparam int SQW          = 96;
	localparam int RTW          = 48;
	localparam int SRW          = 50;
	localparam int CW           = 34;
	localparam int CORDIC_STEPS = 28;
	localparam int STEPW        = 5;
	localparam int SQRT_STEPS   = SQW / 2;
	localparam int ANG_DELAY    = 19;
	localparam int LATE_LEN     = 51;
	localparam int LAT          = 6 + NW + 1 + 52;

	localparam logic [31:0] ANG_HALF = 32'd1 << (31 - ANGLE_BITS);

	typedef struct packed {
		logic [NW-1:0]  n;
		logic [NW-1:0]  q;
		logic [MDW-1:0] r;
		logic [MDW-1:0] d;
	} div_t;

	typedef struct packed {
		logic [SQW-1:0] s;
		logic [RTW-1:0] q;
		logic [SRW-1:0] r;
	} sqrt_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0]          z;
		logic                 zero;
	} cordic_t;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [32:0] vx;
		logic signed [32:0] vy;
		logic               coll;
		logic               dneg;
		logic               negx;
		logic               negy;
	} dside_t;

	typedef struct packed {
		logic        coll;
		logic        dneg;
		logic [47:0] cx;
		logic [47:0] cy;
		logic        csat;
		logic        rovf;
	} late_t;

	typedef struct packed {
		logic [99:0] mx;
		logic [99:0] my;
		logic        nx;
		logic        ny;
	} vec_t;

	typedef struct packed {
		logic [29:0] mx;
		logic [29:0] my;
		logic        nx;
		logic        ny;
		logic        zero;
	} norm_t;

	function automatic logic [31:0] atan_turn(input logic [STEPW-1:0] i);
		logic [31:0] a;
		case (i)
			5'd0: a = 32'h20000000;
			5'd1: a = 32'h12E4051E;
			5'd2: a = 32'h09FB385B;
			5'd3: a = 32'h051111D4;
			5'd4: a = 32'h028B0D43;
			5'd5: a = 32'h0145D7E1;
			5'd6: a = 32'h00A2F61E;
			5'd7: a = 32'h00517C55;
			5'd8: a = 32'h0028BE53;
			5'd9: a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000029;
			5'd25: a = 32'h00000014;
			5'd26: a = 32'h0000000A;
			5'd27: a = 32'h00000005;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

// File: hdl/arc_from_three_points.sv
// Circumcircle and arc of three points in signed Q16.16.
// A word is accepted at a rising edge where start is high and busy is low.
// busy never rises, so a new word may be presented in every cycle.
// Each result word appears on the result ports for exactly one cycle with
// done high; words leave in the order they came in, one per cycle at most.
// The latency is set by the 98-cell divider chain that forms the center
// offset and by the 48-cell square root chain that forms the radius; the
// angles come from a 28-cell CORDIC chain running beside the square root.
// The collinearity threshold is written through cfg_we and cfg_wdata and
// should only change while no word is in flight.
// Reset clears the pipeline valid bits and sets the threshold to 1.
// The receiver cannot stall the block, so no result is ever held back.
module arc_from_three_points (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [31:0]                 p1_x,
	input  logic signed [31:0]                 p1_y,
	input  logic signed [31:0]                 p2_x,
	input  logic signed [31:0]                 p2_y,
	input  logic signed [31:0]                 p3_x,
	input  logic signed [31:0]                 p3_y,
	input  logic                               cfg_we,
	input  logic [31:0]                        cfg_wdata,
	output logic                               done,
	output logic                               ok,
	output logic signed [47:0]                 center_x,
	output logic signed [47:0]                 center_y,
	output logic [46:0]                        radius,
	output logic [afp_pkg::ANGLE_BITS-1:0]     start_angle,
	output logic [afp_pkg::ANGLE_BITS-1:0]     end_angle,
	output logic                               saturated
);

	localparam logic [47:0] CMAX = {1'b0, {47{1'b1}}};
	localparam logic [47:0] CMIN = {1'b1, {47{1'b0}}};
	localparam logic [48:0] RMAX = (49'd1 << 47) - 49'd1;

	function automatic logic [99:0] mag101(input logic signed [100:0] v);
		logic signed [100:0] a;
		a = v[100] ? -v : v;
		return a[99:0];
	endfunction

	function automatic logic [6:0] bitlen100(input logic [99:0] v);
		logic [6:0] n;
		n = '0;
		for (int i = 0; i < 100; i++) begin
			if (v[i]) begin
				n = 7'(i + 1);
			end
		end
		return n;
	endfunction

	function automatic afp_pkg::norm_t normalize(input afp_pkg::vec_t v, input logic [6:0] len);
		afp_pkg::norm_t o;
		logic [99:0]    sx;
		logic [99:0]    sy;
		logic [6:0]     sh;
		sh = (len > 7'd30) ? len - 7'd30 : 7'd0;
		sx = v.mx >> sh;
		sy = v.my >> sh;
		o.mx = sx[29:0];
		o.my = sy[29:0];
		o.nx = v.nx;
		o.ny = v.ny;
		o.zero = (len == 7'd0);
		return o;
	endfunction

	function automatic afp_pkg::cordic_t cordic_init(input afp_pkg::norm_t v);
		afp_pkg::cordic_t              c;
		logic signed [afp_pkg::CW-1:0] xm;
		logic signed [afp_pkg::CW-1:0] ym;
		logic signed [afp_pkg::CW-1:0] xi;
		logic signed [afp_pkg::CW-1:0] yi;
		xm = $signed({{(afp_pkg::CW - 30){1'b0}}, v.mx});
		ym = $signed({{(afp_pkg::CW - 30){1'b0}}, v.my});
		xi = v.nx ? -xm : xm;
		yi = v.ny ? -ym : ym;
		if (v.nx && (v.mx != '0)) begin
			c.x = -xi;
			c.y = -yi;
			c.z = 32'h80000000;
		end else begin
			c.x = xi;
			c.y = yi;
			c.z = '0;
		end
		c.zero = v.zero;
		return c;
	endfunction

	function automatic logic [afp_pkg::ANGLE_BITS-1:0] angle_round(input afp_pkg::cordic_t c);
		logic [31:0] zr;
		zr = c.z + afp_pkg::ANG_HALF;
		return c.zero ? '0 : zr[31 -: afp_pkg::ANGLE_BITS];
	endfunction

	logic [31:0]              thr_q;
	logic [afp_pkg::LAT-1:0]  vld_q;
	logic                     accept;

	logic signed [32:0] ux_s1, uy_s1, vx_s1, vy_s1;
	logic signed [31:0] ax_s1, ay_s1;

	logic signed [65:0] pcx_s2, pcy_s2, puu1_s2, puu2_s2, pvv1_s2, pvv2_s2;
	logic signed [32:0] ux_s2, uy_s2, vx_s2, vy_s2;
	logic signed [31:0] ax_s2, ay_s2;

	logic signed [67:0] d_s3;
	logic [65:0]        uu_s3, vv_s3;
	logic signed [32:0] ux_s3, uy_s3, vx_s3, vy_s3;
	logic signed [31:0] ax_s3, ay_s3;

	logic signed [67:0] dabs;
	logic signed [33:0] uuh, uul, vvh, vvl;
	logic               coll_s4, dneg_s4;
	logic [66:0]        md_s4;
	logic signed [66:0] pxa_s4, pxb_s4, pxc_s4, pxd_s4;
	logic signed [66:0] pya_s4, pyb_s4, pyc_s4, pyd_s4;
	logic signed [32:0] vx_s4, vy_s4;
	logic signed [31:0] ax_s4, ay_s4;

	logic signed [99:0] numx_s5, numy_s5;
	logic               coll_s5, dneg_s5;
	logic [66:0]        md_s5;
	logic signed [32:0] vx_s5, vy_s5;
	logic signed [31:0] ax_s5, ay_s5;

	logic [99:0]        magnx, magny;
	afp_pkg::div_t      divx_s6, divy_s6;
	afp_pkg::dside_t    dside_s6;

	afp_pkg::div_t      divx [afp_pkg::NW+1];
	afp_pkg::div_t      divy [afp_pkg::NW+1];
	afp_pkg::dside_t    dside_q [afp_pkg::NW];

	logic               rndx, rndy;
	logic [98:0]        qrx, qry;
	logic signed [99:0] ox_p0, oy_p0;
	afp_pkg::dside_t    side_p0;

	logic signed [100:0] sumx, sumy;
	logic               inrx, inry;
	logic [99:0]        magx, magy;
	afp_pkg::late_t     late_c;
	afp_pkg::late_t     late_q [afp_pkg::LATE_LEN];

	logic [46:0]        magx_r1, magy_r1;
	logic [45:0]        hhx_r2, hhy_r2;
	logic [46:0]        hlx_r2, hly_r2;
	logic [47:0]        llx_r2, lly_r2;
	afp_pkg::sqrt_t     sq_r3;
	afp_pkg::sqrt_t     sq [afp_pkg::SQRT_STEPS+1];

	logic signed [100:0] nax, nay, nbx, nby;
	afp_pkg::vec_t      va_a1, vb_a1, va_a2, vb_a2;
	logic [6:0]         lena_a2, lenb_a2;
	afp_pkg::norm_t     na_a3, nb_a3;
	afp_pkg::cordic_t   ca_a4, cb_a4;
	afp_pkg::cordic_t   ca [afp_pkg::CORDIC_STEPS+1];
	afp_pkg::cordic_t   cb [afp_pkg::CORDIC_STEPS+1];
	logic [2*afp_pkg::ANGLE_BITS-1:0] ang_q [afp_pkg::ANG_DELAY];

	afp_pkg::late_t     lt;
	logic [48:0]        rad_pre;
	logic [afp_pkg::ANGLE_BITS-1:0] a1, a3;
	logic               ok_q, sat_q;
	logic [47:0]        cx_q, cy_q;
	logic [46:0]        rad_q;
	logic [afp_pkg::ANGLE_BITS-1:0] st_q, en_q;

	assign busy = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 32'd1;
			vld_q <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			vld_q <= {vld_q[afp_pkg::LAT-2:0], accept};
		end
	end

	always_comb begin
		dabs = d_s3[67] ? -d_s3 : d_s3;
		uuh = $signed({1'b0, uu_s3[65:33]});
		uul = $signed({1'b0, uu_s3[32:0]});
		vvh = $signed({1'b0, vv_s3[65:33]});
		vvl = $signed({1'b0, vv_s3[32:0]});
		magnx = numx_s5[99] ? 100'(-numx_s5) : 100'(numx_s5);
		magny = numy_s5[99] ? 100'(-numy_s5) : 100'(numy_s5);
	end

	always_ff @(posedge clk) begin
		ux_s1 <= 33'(p2_x) - 33'(p1_x);
		uy_s1 <= 33'(p2_y) - 33'(p1_y);
		vx_s1 <= 33'(p3_x) - 33'(p1_x);
		vy_s1 <= 33'(p3_y) - 33'(p1_y);
		ax_s1 <= p1_x;
		ay_s1 <= p1_y;

		pcx_s2 <= ux_s1 * vy_s1;
		pcy_s2 <= uy_s1 * vx_s1;
		puu1_s2 <= ux_s1 * ux_s1;
		puu2_s2 <= uy_s1 * uy_s1;
		pvv1_s2 <= vx_s1 * vx_s1;
		pvv2_s2 <= vy_s1 * vy_s1;
		ux_s2 <= ux_s1;
		uy_s2 <= uy_s1;
		vx_s2 <= vx_s1;
		vy_s2 <= vy_s1;
		ax_s2 <= ax_s1;
		ay_s2 <= ay_s1;

		d_s3 <= (68'(pcx_s2) - 68'(pcy_s2)) <<< 1;
		uu_s3 <= 66'(puu1_s2) + 66'(puu2_s2);
		vv_s3 <= 66'(pvv1_s2) + 66'(pvv2_s2);
		ux_s3 <= ux_s2;
		uy_s3 <= uy_s2;
		vx_s3 <= vx_s2;
		vy_s3 <= vy_s2;
		ax_s3 <= ax_s2;
		ay_s3 <= ay_s2;

		coll_s4 <= (d_s3 == '0) || (dabs < $signed({36'd0, thr_q}));
		dneg_s4 <= d_s3[67];
		md_s4 <= dabs[66:0];
		pxa_s4 <= uuh * vy_s3;
		pxb_s4 <= uul * vy_s3;
		pxc_s4 <= vvh * uy_s3;
		pxd_s4 <= vvl * uy_s3;
		pya_s4 <= vvh * ux_s3;
		pyb_s4 <= vvl * ux_s3;
		pyc_s4 <= uuh * vx_s3;
		pyd_s4 <= uul * vx_s3;
		vx_s4 <= vx_s3;
		vy_s4 <= vy_s3;
		ax_s4 <= ax_s3;
		ay_s4 <= ay_s3;

		numx_s5 <= (100'(pxa_s4) <<< 33) + 100'(pxb_s4) - (100'(pxc_s4) <<< 33)
			- 100'(pxd_s4);
		numy_s5 <= (100'(pya_s4) <<< 33) + 100'(pyb_s4) - (100'(pyc_s4) <<< 33)
			- 100'(pyd_s4);
		coll_s5 <= coll_s4;
		dneg_s5 <= dneg_s4;
		md_s5 <= md_s4;
		vx_s5 <= vx_s4;
		vy_s5 <= vy_s4;
		ax_s5 <= ax_s4;
		ay_s5 <= ay_s4;

		divx_s6.n <= magnx[afp_pkg::NW-1:0];
		divx_s6.q <= '0;
		divx_s6.r <= '0;
		divx_s6.d <= md_s5;
		divy_s6.n <= magny[afp_pkg::NW-1:0];
		divy_s6.q <= '0;
		divy_s6.r <= '0;
		divy_s6.d <= md_s5;
		dside_s6.ax <= ax_s5;
		dside_s6.ay <= ay_s5;
		dside_s6.vx <= vx_s5;
		dside_s6.vy <= vy_s5;
		dside_s6.coll <= coll_s5;
		dside_s6.dneg <= dneg_s5;
		dside_s6.negx <= numx_s5[99] ^ dneg_s5;
		dside_s6.negy <= numy_s5[99] ^ dneg_s5;

		dside_q[0] <= dside_s6;
		for (int i = 1; i < afp_pkg::NW; i++) begin
			dside_q[i] <= dside_q[i-1];
		end
	end

	assign divx[0] = divx_s6;
	assign divy[0] = divy_s6;

	for (genvar g = 0; g < afp_pkg::NW; g++) begin : g_div
		afp_div_cell u_cx (.clk(clk), .din(divx[g]), .dout(divx[g+1]));
		afp_div_cell u_cy (.clk(clk), .din(divy[g]), .dout(divy[g+1]));
	end

	always_comb begin
		rndx = {divx[afp_pkg::NW].r, 1'b0} >= {1'b0, divx[afp_pkg::NW].d};
		rndy = {divy[afp_pkg::NW].r, 1'b0} >= {1'b0, divy[afp_pkg::NW].d};
		qrx = {1'b0, divx[afp_pkg::NW].q} + {98'd0, rndx};
		qry = {1'b0, divy[afp_pkg::NW].q} + {98'd0, rndy};
	end

	always_ff @(posedge clk) begin
		ox_p0 <= dside_q[afp_pkg::NW-1].negx ? -$signed({1'b0, qrx}) : $signed({1'b0, qrx});
		oy_p0 <= dside_q[afp_pkg::NW-1].negy ? -$signed({1'b0, qry}) : $signed({1'b0, qry});
		side_p0 <= dside_q[afp_pkg::NW-1];
	end

	always_comb begin
		sumx = 101'($signed(side_p0.ax)) + 101'(ox_p0);
		sumy = 101'($signed(side_p0.ay)) + 101'(oy_p0);
		inrx = (&sumx[100:47]) | ~(|sumx[100:47]);
		inry = (&sumy[100:47]) | ~(|sumy[100:47]);
		magx = ox_p0[99] ? 100'(-ox_p0) : 100'(ox_p0);
		magy = oy_p0[99] ? 100'(-oy_p0) : 100'(oy_p0);
		late_c.coll = side_p0.coll;
		late_c.dneg = side_p0.dneg;
		late_c.cx = inrx ? sumx[47:0] : (sumx[100] ? CMIN : CMAX);
		late_c.cy = inry ? sumy[47:0] : (sumy[100] ? CMIN : CMAX);
		late_c.csat = ~inrx | ~inry;
		late_c.rovf = (|magx[99:47]) | (|magy[99:47]);
		nax = -101'(ox_p0);
		nay = -101'(oy_p0);
		nbx = 101'($signed(side_p0.vx)) - 101'(ox_p0);
		nby = 101'($signed(side_p0.vy)) - 101'(oy_p0);
	end

	always_ff @(posedge clk) begin
		late_q[0] <= late_c;
		for (int i = 1; i < afp_pkg::LATE_LEN; i++) begin
			late_q[i] <= late_q[i-1];
		end

		magx_r1 <= magx[46:0];
		magy_r1 <= magy[46:0];

		hhx_r2 <= magx_r1[46:24] * magx_r1[46:24];
		hlx_r2 <= magx_r1[46:24] * magx_r1[23:0];
		llx_r2 <= magx_r1[23:0] * magx_r1[23:0];
		hhy_r2 <= magy_r1[46:24] * magy_r1[46:24];
		hly_r2 <= magy_r1[46:24] * magy_r1[23:0];
		lly_r2 <= magy_r1[23:0] * magy_r1[23:0];

		sq_r3.s <= (96'(hhx_r2) << 48) + (96'(hlx_r2) << 25) + 96'(llx_r2)
			+ (96'(hhy_r2) << 48) + (96'(hly_r2) << 25) + 96'(lly_r2);
		sq_r3.q <= '0;
		sq_r3.r <= '0;

		va_a1.mx <= mag101(nax);
		va_a1.my <= mag101(nay);
		va_a1.nx <= nax[100];
		va_a1.ny <= nay[100];
		vb_a1.mx <= mag101(nbx);
		vb_a1.my <= mag101(nby);
		vb_a1.nx <= nbx[100];
		vb_a1.ny <= nby[100];

		va_a2 <= va_a1;
		vb_a2 <= vb_a1;
		lena_a2 <= bitlen100(va_a1.mx | va_a1.my);
		lenb_a2 <= bitlen100(vb_a1.mx | vb_a1.my);

		na_a3 <= normalize(va_a2, lena_a2);
		nb_a3 <= normalize(vb_a2, lenb_a2);

		ca_a4 <= cordic_init(na_a3);
		cb_a4 <= cordic_init(nb_a3);

		ang_q[0] <= {angle_round(ca[afp_pkg::CORDIC_STEPS]),
			angle_round(cb[afp_pkg::CORDIC_STEPS])};
		for (int i = 1; i < afp_pkg::ANG_DELAY; i++) begin
			ang_q[i] <= ang_q[i-1];
		end
	end

	assign sq[0] = sq_r3;

	for (genvar g = 0; g < afp_pkg::SQRT_STEPS; g++) begin : g_sqrt
		afp_sqrt_cell u_cell (.clk(clk), .din(sq[g]), .dout(sq[g+1]));
	end

	assign ca[0] = ca_a4;
	assign cb[0] = cb_a4;

	for (genvar g = 0; g < afp_pkg::CORDIC_STEPS; g++) begin : g_cordic
		localparam logic [afp_pkg::STEPW-1:0] STEP = afp_pkg::STEPW'(g);
		afp_cordic_cell u_ca (.clk(clk), .step(STEP), .din(ca[g]), .dout(ca[g+1]));
		afp_cordic_cell u_cb (.clk(clk), .step(STEP), .din(cb[g]), .dout(cb[g+1]));
	end

	always_comb begin
		lt = late_q[afp_pkg::LATE_LEN-1];
		rad_pre = {1'b0, sq[afp_pkg::SQRT_STEPS].q}
			+ {48'd0, (sq[afp_pkg::SQRT_STEPS].r > {2'b00, sq[afp_pkg::SQRT_STEPS].q})};
		a1 = ang_q[afp_pkg::ANG_DELAY-1][2*afp_pkg::ANGLE_BITS-1:afp_pkg::ANGLE_BITS];
		a3 = ang_q[afp_pkg::ANG_DELAY-1][afp_pkg::ANGLE_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (lt.coll) begin
			ok_q <= 1'b0;
			cx_q <= '0;
			cy_q <= '0;
			rad_q <= '0;
			st_q <= '0;
			en_q <= '0;
			sat_q <= 1'b0;
		end else begin
			ok_q <= 1'b1;
			cx_q <= lt.cx;
			cy_q <= lt.cy;
			rad_q <= (lt.rovf || rad_pre > RMAX) ? RMAX[46:0] : rad_pre[46:0];
			st_q <= lt.dneg ? a3 : a1;
			en_q <= lt.dneg ? a1 : a3;
			sat_q <= lt.csat | lt.rovf | (rad_pre > RMAX);
		end
	end

	assign done = vld_q[afp_pkg::LAT-1];
	assign ok = ok_q;
	assign center_x = cx_q;
	assign center_y = cy_q;
	assign radius = rad_q;
	assign start_angle = st_q;
	assign end_angle = en_q;
	assign saturated = sat_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(afp_pkg::LAT) done)
		else $error("accepted word did not come out after the pipeline latency");

	a_collinear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (center_x == '0 && center_y == '0 && radius == '0
			&& start_angle == '0 && end_angle == '0 && !saturated))
		else $error("collinear result carries nonzero fields");
`endif

endmodule

// File: hdl/afp_div_cell.sv
module afp_div_cell (
	input  logic          clk,
	input  afp_pkg::div_t din,
	output afp_pkg::div_t dout
);

	logic [afp_pkg::MDW:0] rr;
	logic [afp_pkg::MDW:0] diff;
	afp_pkg::div_t         nxt;
	afp_pkg::div_t         cell_q;

	always_comb begin
		rr = {din.r, din.n[afp_pkg::NW-1]};
		diff = rr - {1'b0, din.d};
		nxt = din;
		nxt.n = din.n << 1;
		if (rr >= {1'b0, din.d}) begin
			nxt.r = diff[afp_pkg::MDW-1:0];
			nxt.q = {din.q[afp_pkg::NW-2:0], 1'b1};
		end else begin
			nxt.r = rr[afp_pkg::MDW-1:0];
			nxt.q = {din.q[afp_pkg::NW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= nxt;
	end

	assign dout = cell_q;

endmodule

// File: hdl/afp_sqrt_cell.sv
module afp_sqrt_cell (
	input  logic           clk,
	input  afp_pkg::sqrt_t din,
	output afp_pkg::sqrt_t dout
);

	logic [afp_pkg::SRW+1:0] rr;
	logic [afp_pkg::SRW+1:0] trial;
	logic [afp_pkg::SRW+1:0] diff;
	afp_pkg::sqrt_t          nxt;
	afp_pkg::sqrt_t          cell_q;

	always_comb begin
		rr = {din.r, din.s[afp_pkg::SQW-1:afp_pkg::SQW-2]};
		trial = {{(afp_pkg::SRW - afp_pkg::RTW){1'b0}}, din.q, 2'b01};
		diff = rr - trial;
		nxt = din;
		nxt.s = din.s << 2;
		if (rr >= trial) begin
			nxt.r = diff[afp_pkg::SRW-1:0];
			nxt.q = {din.q[afp_pkg::RTW-2:0], 1'b1};
		end else begin
			nxt.r = rr[afp_pkg::SRW-1:0];
			nxt.q = {din.q[afp_pkg::RTW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= nxt;
	end

	assign dout = cell_q;

endmodule

// File: hdl/afp_cordic_cell.sv
module afp_cordic_cell (
	input  logic                      clk,
	input  logic [afp_pkg::STEPW-1:0] step,
	input  afp_pkg::cordic_t          din,
	output afp_pkg::cordic_t          dout
);

	logic signed [afp_pkg::CW-1:0] xs;
	logic signed [afp_pkg::CW-1:0] ys;
	logic signed [afp_pkg::CW-1:0] dx;
	logic signed [afp_pkg::CW-1:0] dy;
	afp_pkg::cordic_t              nxt;
	afp_pkg::cordic_t              cell_q;

	always_comb begin
		xs = din.x;
		ys = din.y;
		dx = ys >>> step;
		dy = xs >>> step;
		nxt = din;
		if (ys > 0) begin
			nxt.x = xs + dx;
			nxt.y = ys - dy;
			nxt.z = din.z + afp_pkg::atan_turn(step);
		end else begin
			nxt.x = xs - dx;
			nxt.y = ys + dy;
			nxt.z = din.z - afp_pkg::atan_turn(step);
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= nxt;
	end

	assign dout = cell_q;

endmodule
